FILE: design/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Types, register indexes and reset values shared by the heater setpoint
// controller modules.
// ----------------------------------------------------------------------------
package hsc_pkg;

	localparam int SP_W      = 7;
	localparam int TEMP_W    = 12;
	localparam int LOW_W     = 10;
	localparam int BLINK_W   = 12;
	localparam int SAVE_W    = 16;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MAX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SETPOINT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_CONFIRM    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAVE_DELAY       = 3'd5;

	// register reset values
	localparam logic [SP_W-1:0]    RST_SETPOINT_MIN     = 7'd10;
	localparam logic [SP_W-1:0]    RST_SETPOINT_MAX     = 7'd60;
	localparam logic [SP_W-1:0]    RST_INITIAL_SETPOINT = 7'd36;
	localparam logic [LOW_W-1:0]   RST_PRESS_CONFIRM    = 10'd200;
	localparam logic [BLINK_W-1:0] RST_BLINK_PERIOD     = 12'd1000;
	localparam logic [SAVE_W-1:0]  RST_SAVE_DELAY       = 16'd5000;

	localparam logic [TEMP_W-1:0] TEMP_MOST_NEGATIVE = 12'h800;

	// status codes
	localparam logic [STATUS_W-1:0] ST_READY   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_HEATING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd2;

	typedef struct packed {
		logic [SP_W-1:0]    setpoint_min;
		logic [SP_W-1:0]    setpoint_max;
		logic [LOW_W-1:0]   press_confirm;
		logic [BLINK_W-1:0] blink_period;
		logic [SAVE_W-1:0]  save_delay;
	} cfg_t;

	typedef struct packed {
		logic [SP_W-1:0]    setpoint;
		logic [TEMP_W-1:0]  current_temp;
		logic               heater;
		logic               press_latched;
		logic [LOW_W-1:0]   low_count;
		logic               clk_last;
		logic               blink_flag;
		logic [BLINK_W-1:0] blink_timer;
		logic               saved;
		logic [SAVE_W-1:0]  save_timer;
	} state_t;

	typedef struct packed {
		logic              enc_clk;
		logic              enc_dt;
		logic              button_level;
		logic              temp_valid;
		logic [TEMP_W-1:0] temp_sixteenths;
	} item_t;

	typedef struct packed {
		logic                heater_on;
		logic [SP_W-1:0]     setpoint;
		logic [STATUS_W-1:0] status;
		logic                heat_blink;
		logic                save_strobe;
	} result_t;

endpackage

FILE: design/hsc_step.sv
// ----------------------------------------------------------------------------
// hsc_step
// Next-state and result logic for one millisecond tick.
// ----------------------------------------------------------------------------
module hsc_step (
	input  hsc_pkg::cfg_t    cfg,
	input  hsc_pkg::state_t  cur,
	input  hsc_pkg::item_t   item,
	output hsc_pkg::state_t  nxt,
	output hsc_pkg::result_t res
);
	import hsc_pkg::*;

	logic [TEMP_W-1:0] temp;
	logic signed [SP_W+1:0] sp_step;
	logic signed [SP_W+1:0] sp_lo;
	logic [SP_W-1:0] sp_new;
	logic exceeds;
	logic [LOW_W-1:0] low_new;
	logic pressed;
	logic heater_new;
	logic latched_new;
	logic saved_mid;

	always_comb begin
		temp = item.temp_valid ? item.temp_sixteenths : cur.current_temp;

		// one step per clock pin change, down when data differs from clock
		if (item.enc_dt != item.enc_clk) begin
			sp_step = $signed({2'b00, cur.setpoint}) - 9'sd1;
		end else begin
			sp_step = $signed({2'b00, cur.setpoint}) + 9'sd1;
		end
		sp_lo = (sp_step < $signed({2'b00, cfg.setpoint_min})) ?
			$signed({2'b00, cfg.setpoint_min}) : sp_step;
		if (sp_lo > $signed({2'b00, cfg.setpoint_max})) begin
			sp_lo = $signed({2'b00, cfg.setpoint_max});
		end

		if (item.enc_clk != cur.clk_last) begin
			sp_new    = sp_lo[SP_W-1:0];
			saved_mid = 1'b0;
		end else begin
			sp_new    = cur.setpoint;
			saved_mid = cur.saved;
		end

		exceeds = $signed(temp) > $signed({1'b0, sp_new, 4'b0000});

		// debounce
		if (item.button_level) begin
			low_new = '0;
		end else if (cur.low_count != {LOW_W{1'b1}}) begin
			low_new = cur.low_count + 1'b1;
		end else begin
			low_new = cur.low_count;
		end
		pressed = !item.button_level && (low_new >= cfg.press_confirm);

		// over-temperature wins over the button
		heater_new  = cur.heater;
		latched_new = cur.press_latched;
		if (exceeds && cur.heater) begin
			heater_new = 1'b0;
		end else if (pressed && !cur.press_latched) begin
			heater_new  = !cur.heater;
			latched_new = 1'b1;
		end else if (!pressed) begin
			latched_new = 1'b0;
		end

		nxt               = cur;
		nxt.setpoint      = sp_new;
		nxt.current_temp  = temp;
		nxt.heater        = heater_new;
		nxt.press_latched = latched_new;
		nxt.low_count     = low_new;
		nxt.clk_last      = item.enc_clk;
		nxt.saved         = saved_mid;

		if (heater_new && (cur.blink_timer >= cfg.blink_period)) begin
			nxt.blink_flag  = !cur.blink_flag;
			nxt.blink_timer = '0;
		end else if (cur.blink_timer != {BLINK_W{1'b1}}) begin
			nxt.blink_timer = cur.blink_timer + 1'b1;
		end
		if (!heater_new) begin
			nxt.blink_flag = 1'b0;
		end

		res.save_strobe = 1'b0;
		if (!saved_mid && (cur.save_timer >= cfg.save_delay)) begin
			nxt.saved       = 1'b1;
			nxt.save_timer  = '0;
			res.save_strobe = 1'b1;
		end else if (cur.save_timer != {SAVE_W{1'b1}}) begin
			nxt.save_timer = cur.save_timer + 1'b1;
		end

		if (exceeds) begin
			res.status = ST_READY;
		end else if (cur.heater) begin
			res.status = ST_HEATING;
		end else begin
			res.status = ST_IDLE;
		end
		res.heater_on  = heater_new;
		res.setpoint   = sp_new;
		res.heat_blink = nxt.blink_flag;
	end

endmodule

FILE: design/heater_setpoint_controller.sv
// ----------------------------------------------------------------------------
// heater_setpoint_controller
// Encoder-driven setpoint, debounced heater toggle with over-temperature
// cutoff, heating blink flag and delayed save strobe; one request per tick.
// ----------------------------------------------------------------------------
//
//   channel  handshake               payload
//   -------  ----------------------  ----------------------------------------
//   in       in_valid / in_ready     enc_clk enc_dt button_level temp_valid
//                                    temp_sixteenths
//   out      out_valid / out_ready   heater_on setpoint status heat_blink
//                                    save_strobe
//   cfg      cfg_wr_en               cfg_index cfg_wdata (write only)
//
// A request is held in the input register, then processed into the result
// register; one request per cycle is sustained while out_ready is high.
// The single input register and single result register set that rate.
// Reset clears control state, loads register defaults and the tick state.
// A stalled result holds; the input register still takes one more request
// and then holds until the result drains.
// ----------------------------------------------------------------------------
module heater_setpoint_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  enc_clk,
	input  logic                                  enc_dt,
	input  logic                                  button_level,
	input  logic                                  temp_valid,
	input  logic signed [hsc_pkg::TEMP_W-1:0]     temp_sixteenths,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  heater_on,
	output logic [hsc_pkg::SP_W-1:0]              setpoint,
	output logic [hsc_pkg::STATUS_W-1:0]          status,
	output logic                                  heat_blink,
	output logic                                  save_strobe,
	input  logic                                  cfg_wr_en,
	input  logic [hsc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [hsc_pkg::CFG_DAT_W-1:0]         cfg_wdata
);
	import hsc_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	// configuration writes; the initial setpoint only matters at reset, so
	// a later write to it has no effect
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_min  <= RST_SETPOINT_MIN;
			cfg_q.setpoint_max  <= RST_SETPOINT_MAX;
			cfg_q.press_confirm <= RST_PRESS_CONFIRM;
			cfg_q.blink_period  <= RST_BLINK_PERIOD;
			cfg_q.save_delay    <= RST_SAVE_DELAY;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SETPOINT_MIN:     cfg_q.setpoint_min  <= cfg_wdata[SP_W-1:0];
				REG_SETPOINT_MAX:     cfg_q.setpoint_max  <= cfg_wdata[SP_W-1:0];
				REG_INITIAL_SETPOINT: ;
				REG_PRESS_CONFIRM:    cfg_q.press_confirm <= cfg_wdata[LOW_W-1:0];
				REG_BLINK_PERIOD:     cfg_q.blink_period  <= cfg_wdata[BLINK_W-1:0];
				REG_SAVE_DELAY:       cfg_q.save_delay    <= cfg_wdata[SAVE_W-1:0];
				default: ;
			endcase
		end
	end

	// process the held request when the result slot is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.enc_clk         <= enc_clk;
			item_s1.enc_dt          <= enc_dt;
			item_s1.button_level    <= button_level;
			item_s1.temp_valid      <= temp_valid;
			item_s1.temp_sixteenths <= temp_sixteenths;
		end
	end

	hsc_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// tick state advances only when a request is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.setpoint      <= RST_INITIAL_SETPOINT;
			state_q.current_temp  <= TEMP_MOST_NEGATIVE;
			state_q.heater        <= 1'b0;
			state_q.press_latched <= 1'b0;
			state_q.low_count     <= '0;
			state_q.clk_last      <= 1'b0;
			state_q.blink_flag    <= 1'b0;
			state_q.blink_timer   <= '0;
			state_q.saved         <= 1'b1;
			state_q.save_timer    <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign heater_on   = res_s2.heater_on;
	assign setpoint    = res_s2.setpoint;
	assign status      = res_s2.status;
	assign heat_blink  = res_s2.heat_blink;
	assign save_strobe = res_s2.save_strobe;

endmodule
